[design/zero_run_length_decoder_defines.svh]
// Assertion macros for the zero-run-length decoder checker.
// No dependencies; included by zrld_checker, the file that carries assertions.
`ifndef ZERO_RUN_LENGTH_DECODER_DEFINES_SVH
`define ZERO_RUN_LENGTH_DECODER_DEFINES_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define ZRLD_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk, off during reset.
`define ZRLD_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[design/zrld_pkg.sv]
// Shared types and constants for the zero-run-length decoder.
// No dependencies; imported by every module of the block.
`default_nettype none

package zrld_pkg;

	localparam int RUN_DIGITS = 31;
	localparam int COUNT_W    = 6;
	localparam int BITS_W     = 32;
	localparam int LEN_W      = 32;

	localparam logic [LEN_W-1:0] LEN_MAX = 32'hffff_fffe;
	localparam logic [63:0] RUN_CAP_WIDE = (64'd1 << (RUN_DIGITS + 1)) - 64'd2;
	localparam logic [LEN_W-1:0] RUN_CAP = (RUN_DIGITS >= 31) ? LEN_MAX : RUN_CAP_WIDE[LEN_W-1:0];
	localparam logic [COUNT_W-1:0] DIGIT_LIMIT = COUNT_W'(RUN_DIGITS);
	localparam logic [COUNT_W-1:0] BITS_LIMIT  = COUNT_W'(BITS_W);

	localparam logic [7:0] BYTE_ESC     = 8'hff;
	localparam logic [7:0] BYTE_ESC_ZERO = 8'hfe;

	// command queue between front and back; power of two so pointers wrap
	localparam int QDEPTH = 4;
	localparam int QPTR_W = $clog2(QDEPTH);

	typedef enum logic {
		ACT_DATA = 1'b0,
		ACT_END  = 1'b1
	} action_t;

	typedef enum logic [1:0] {
		KIND_LITERAL = 2'd0,
		KIND_RUN     = 2'd1,
		KIND_END_OK  = 2'd2,
		KIND_END_ERR = 2'd3
	} kind_t;

	typedef struct packed {
		action_t    action;
		logic [7:0] in_byte;
	} in_beat_t;

	typedef struct packed {
		kind_t             kind;
		logic [7:0]        value;
		logic [LEN_W-1:0]  run_length;
		logic              run_saturated;
		logic              last;
	} out_beat_t;

	// one queue entry: an optional run snapshot, then an optional literal or end result
	typedef struct packed {
		logic               run_valid;
		logic [BITS_W-1:0]  run_bits;
		logic [COUNT_W-1:0] run_count;
		logic               run_ovf;
		logic               tail_valid;
		kind_t              tail_kind;
		logic [7:0]         tail_value;
	} cmd_t;

	typedef struct packed {
		logic push;
		logic full;
	} q_wr_t;

	typedef struct packed {
		logic pop;
		logic empty;
	} q_rd_t;

endpackage

`default_nettype wire

[design/zrld_queue.sv]
// Small command queue between the front and back halves.
// Depends on zrld_pkg.
`default_nettype none

module zrld_queue (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          push,
	input  zrld_pkg::cmd_t     wr_cmd,
	output zrld_pkg::q_wr_t    wr_ctl,
	input  wire logic          pop,
	output zrld_pkg::cmd_t     rd_cmd,
	output zrld_pkg::q_rd_t    rd_ctl
);
	import zrld_pkg::*;

	cmd_t               mem_q [QDEPTH];
	logic [QPTR_W-1:0]  wr_ptr_q;
	logic [QPTR_W-1:0]  rd_ptr_q;
	logic [QPTR_W:0]    count_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push)
				wr_ptr_q <= wr_ptr_q + QPTR_W'(1);
			if (pop)
				rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
			if (push && !pop)
				count_q <= count_q + (QPTR_W+1)'(1);
			else if (pop && !push)
				count_q <= count_q - (QPTR_W+1)'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_ptr_q] <= wr_cmd;
	end

	assign rd_cmd       = mem_q[rd_ptr_q];
	assign rd_ctl.pop   = pop;
	assign rd_ctl.empty = (count_q == '0);
	assign wr_ctl.push  = push;
	assign wr_ctl.full  = (count_q == (QPTR_W+1)'(QDEPTH));

endmodule

`default_nettype wire

[design/zrld_front.sv]
// Front half: takes input beats, tracks run/escape state, queues commands.
// Depends on zrld_pkg.
`default_nettype none

module zrld_front (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          byte_valid,
	output logic               byte_stall,
	input  zrld_pkg::in_beat_t byte_beat,
	input  zrld_pkg::q_wr_t    q_ctl,
	output logic               push,
	output zrld_pkg::cmd_t     cmd
);
	import zrld_pkg::*;

	logic [BITS_W-1:0]  bits_q, bits_d;
	logic [COUNT_W-1:0] count_q, count_d;
	logic               esc_q, esc_d;
	logic               ovf_q, ovf_d;
	logic               accept;
	logic [7:0]         b;

	assign byte_stall = q_ctl.full;
	assign accept     = byte_valid && !q_ctl.full;
	assign b          = byte_beat.in_byte;

	always_comb begin
		bits_d  = bits_q;
		count_d = count_q;
		esc_d   = esc_q;
		ovf_d   = ovf_q;

		cmd.run_valid  = 1'b0;
		cmd.run_bits   = bits_q;
		cmd.run_count  = count_q;
		cmd.run_ovf    = ovf_q;
		cmd.tail_valid = 1'b0;
		cmd.tail_kind  = KIND_LITERAL;
		cmd.tail_value = '0;

		if (byte_beat.action == ACT_END) begin
			cmd.run_valid  = !esc_q && (count_q != '0);
			cmd.tail_valid = 1'b1;
			cmd.tail_kind  = esc_q ? KIND_END_ERR : KIND_END_OK;
			bits_d  = '0;
			count_d = '0;
			esc_d   = 1'b0;
			ovf_d   = 1'b0;
		end else if (esc_q) begin
			esc_d          = 1'b0;
			cmd.tail_valid = 1'b1;
			cmd.tail_value = (b != 8'd0) ? BYTE_ESC : BYTE_ESC_ZERO;
		end else if (b <= 8'd1) begin
			// run digit, LSB first
			if (count_q >= DIGIT_LIMIT) begin
				ovf_d = 1'b1;
			end else begin
				if (b[0] && (count_q < BITS_LIMIT))
					bits_d[count_q[$clog2(BITS_W)-1:0]] = 1'b1;
				count_d = count_q + COUNT_W'(1);
			end
		end else begin
			// closes any pending run
			cmd.run_valid = (count_q != '0);
			bits_d  = '0;
			count_d = '0;
			ovf_d   = 1'b0;
			if (b == BYTE_ESC) begin
				esc_d = 1'b1;
			end else begin
				cmd.tail_valid = 1'b1;
				cmd.tail_value = b - 8'd1;
			end
		end

		push = accept && (cmd.run_valid || cmd.tail_valid);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bits_q  <= '0;
			count_q <= '0;
			esc_q   <= 1'b0;
			ovf_q   <= 1'b0;
		end else if (accept) begin
			bits_q  <= bits_d;
			count_q <= count_d;
			esc_q   <= esc_d;
			ovf_q   <= ovf_d;
		end
	end

endmodule

`default_nettype wire

[design/zrld_back.sv]
// Back half: drains the queue into results, one per unstalled cycle.
// Depends on zrld_pkg.
`default_nettype none

module zrld_back (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  zrld_pkg::cmd_t      head,
	input  zrld_pkg::q_rd_t     q_ctl,
	output logic                pop,
	output logic                result_valid,
	input  wire logic           result_stall,
	output zrld_pkg::out_beat_t result_beat
);
	import zrld_pkg::*;

	logic              phase_q;
	logic              valid_q;
	out_beat_t         beat_q;
	out_beat_t         beat_d;
	logic              can_load;
	logic              issue;
	logic              emit_run;
	logic [LEN_W-1:0]  pow;
	logic [LEN_W-1:0]  len;
	logic              sat;

	assign can_load = !valid_q || !result_stall;
	assign issue    = can_load && !q_ctl.empty;
	assign emit_run = head.run_valid && !phase_q;

	always_comb begin
		pow = '0;
		if (head.run_count < BITS_LIMIT)
			pow = LEN_W'(1) << head.run_count[$clog2(LEN_W)-1:0];
		if (head.run_ovf) begin
			len = RUN_CAP;
			sat = 1'b1;
		end else if (head.run_count >= BITS_LIMIT) begin
			len = LEN_MAX;
			sat = 1'b1;
		end else begin
			len = (pow | head.run_bits) - LEN_W'(1);
			sat = 1'b0;
		end
	end

	always_comb begin
		if (emit_run) begin
			beat_d.kind          = KIND_RUN;
			beat_d.value         = '0;
			beat_d.run_length    = len;
			beat_d.run_saturated = sat;
			beat_d.last          = !head.tail_valid;
		end else begin
			beat_d.kind          = head.tail_kind;
			beat_d.value         = head.tail_value;
			beat_d.run_length    = '0;
			beat_d.run_saturated = 1'b0;
			beat_d.last          = 1'b1;
		end
		pop = issue && !(emit_run && head.tail_valid);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= 1'b0;
			valid_q <= 1'b0;
		end else begin
			if (issue)
				phase_q <= emit_run && head.tail_valid;
			if (can_load)
				valid_q <= issue;
		end
	end

	always_ff @(posedge clk) begin
		if (issue)
			beat_q <= beat_d;
	end

	assign result_valid = valid_q;
	assign result_beat  = beat_q;

endmodule

`default_nettype wire

[design/zero_run_length_decoder.sv]
// Zero-run-length decoder. Takes one encoded byte per beat (or an end-of-stream
// beat) and returns literal, zero-run and end results. Bytes 0 and 1 are
// bijective base-2 digits of a run length, LSB first; any other byte or the end
// of stream closes the run, which comes out as one result with its length.
// 0xff escapes the next byte; other bytes decode to byte minus 1. The input
// side takes one beat per clock whenever the four-entry command queue has room;
// the output side delivers one result per clock while result_stall is low, so
// a byte that closes a run and carries a literal yields two results, and the
// queue soaks up the difference. Sustained rate: one byte per cycle, bounded by
// one result per cycle at the output register, while result_stall is low. With
// an empty queue, an accepted byte's command is written into the queue and its
// first result then loads the output register. byte_stall rises only when the
// queue is full; result_valid comes from a register.
// Depends on zrld_pkg, zrld_front, zrld_queue, zrld_back.
`default_nettype none

module zero_run_length_decoder (
	input  wire logic           clk,
	input  wire logic           arst_n,
	// input beats
	input  wire logic           byte_valid,
	output logic                byte_stall,
	input  zrld_pkg::in_beat_t  byte_beat,
	// result beats
	output logic                result_valid,
	input  wire logic           result_stall,
	output zrld_pkg::out_beat_t result_beat
);
	import zrld_pkg::*;

	cmd_t  wr_cmd;
	cmd_t  rd_cmd;
	q_wr_t wr_ctl;
	q_rd_t rd_ctl;
	logic  push;
	logic  pop;

	// front: run/escape state, turns bytes that yield results into queue commands
	zrld_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.byte_valid (byte_valid),
		.byte_stall (byte_stall),
		.byte_beat  (byte_beat),
		.q_ctl      (wr_ctl),
		.push       (push),
		.cmd        (wr_cmd)
	);

	zrld_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.wr_cmd (wr_cmd),
		.wr_ctl (wr_ctl),
		.pop    (pop),
		.rd_cmd (rd_cmd),
		.rd_ctl (rd_ctl)
	);

	// back: run length math and result sequencing into the output register
	zrld_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.head         (rd_cmd),
		.q_ctl        (rd_ctl),
		.pop          (pop),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result_beat  (result_beat)
	);

endmodule

`default_nettype wire

[design/zrld_checker.sv]
// Port-level checks for the zero-run-length decoder, bound to the top level.
// Depends on zrld_pkg and zero_run_length_decoder_defines.svh.
`default_nettype none
`include "zero_run_length_decoder_defines.svh"

module zrld_checker (
	input wire logic           clk,
	input wire logic           arst_n,
	input wire logic           byte_valid,
	input wire logic           byte_stall,
	input zrld_pkg::in_beat_t  byte_beat,
	input wire logic           result_valid,
	input wire logic           result_stall,
	input zrld_pkg::out_beat_t result_beat
);
	import zrld_pkg::*;

	`ZRLD_ASSERT_NEXT(a_in_hold, byte_valid && byte_stall,
		byte_valid && $stable(byte_beat), "stalled input beat changed")
	`ZRLD_ASSERT_NEXT(a_out_hold, result_valid && result_stall,
		result_valid && $stable(result_beat), "stalled result beat changed")
	`ZRLD_ASSERT_NOW(a_end_last,
		result_valid && (result_beat.kind == KIND_END_OK || result_beat.kind == KIND_END_ERR),
		result_beat.last, "end result not marked last")
	`ZRLD_ASSERT_NOW(a_non_run_clean, result_valid && result_beat.kind != KIND_RUN,
		result_beat.run_length == '0 && !result_beat.run_saturated,
		"non-run result carries run fields")
	`ZRLD_ASSERT_NOW(a_run_clean, result_valid && result_beat.kind == KIND_RUN,
		result_beat.value == '0 && result_beat.run_length != 32'hffff_ffff,
		"run result malformed")

endmodule

bind zero_run_length_decoder zrld_checker u_zrld_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.byte_valid   (byte_valid),
	.byte_stall   (byte_stall),
	.byte_beat    (byte_beat),
	.result_valid (result_valid),
	.result_stall (result_stall),
	.result_beat  (result_beat)
);

`default_nettype wire

[tb/sv/tb_zero_run_length_decoder.sv]
// Self-checking testbench for zero_run_length_decoder: directed and random byte streams
// under varying idle and stall patterns. Depends on zrld_pkg and the decoder RTL.
`default_nettype none

module tb_zero_run_length_decoder;
	timeunit 1ns;
	timeprecision 1ps;

	import zrld_pkg::*;

	localparam int     RESET_CYCLES = 10;
	localparam int     HOLD_CYCLES  = 300;    // long receiver hold-off
	localparam int     DRAIN_CYCLES = 20;     // extra cycles after the last result
	localparam int     MAX_REPORTS  = 10;
	localparam longint TIMEOUT_NS   = 64'd6_000_000;  // watchdog limit in ns

	logic      clk = 1'b0;
	logic      arst_n = 1'b0;
	logic      byte_valid = 1'b0;
	logic      byte_stall;
	in_beat_t  byte_beat = '0;
	logic      result_valid;
	logic      result_stall = 1'b0;
	out_beat_t result_beat;

	zero_run_length_decoder uut (
		.clk          (clk),
		.arst_n       (arst_n),
		.byte_valid   (byte_valid),
		.byte_stall   (byte_stall),
		.byte_beat    (byte_beat),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result_beat  (result_beat)
	);

	// 12 ns clock
	always begin
		clk = 1'b0;
		#6;
		clk = 1'b1;
		#6;
	end

	// knobs set by the test tasks
	int   src_idle_pct  = 0;
	int   sink_stall_pct = 0;
	logic hold_active   = 1'b0;
	event hold_go;

	int err_cnt    = 0;
	int result_idx = 0;
	int beats_sent = 0;

	// decoded results still owed by the block, oldest first
	out_beat_t pending_results[$];

	// predictor state: digits of the open run, escape flag, digit overflow
	logic [BITS_W-1:0]  acc_bits     = '0;
	logic [COUNT_W-1:0] acc_digits   = '0;
	logic               esc_seen     = 1'b0;
	logic               acc_overflow = 1'b0;

	function automatic out_beat_t plain_result(kind_t k, logic [7:0] v);
		out_beat_t r;
		r = '0;
		r.kind  = k;
		r.value = v;
		return r;
	endfunction

	// Close the open run: exact length, or the cap once digits were dropped.
	function automatic out_beat_t close_run();
		out_beat_t   r;
		logic [63:0] wide;
		r = plain_result(KIND_RUN, 8'h00);
		if (acc_overflow) begin
			r.run_length    = RUN_CAP;
			r.run_saturated = 1'b1;
		end else if (acc_digits > COUNT_W'(BITS_W - 1)) begin
			r.run_length    = LEN_MAX;
			r.run_saturated = 1'b1;
		end else begin
			wide = ((64'd1 << acc_digits) | 64'(acc_bits)) - 64'd1;
			r.run_length = wide[LEN_W-1:0];
		end
		acc_bits     = '0;
		acc_digits   = '0;
		acc_overflow = 1'b0;
		return r;
	endfunction

	// Work out the results of one accepted beat and queue them.
	task automatic decode_beat(input in_beat_t b);
		out_beat_t res[$];
		if (b.action == ACT_END) begin
			if (esc_seen) begin
				res.push_back(plain_result(KIND_END_ERR, 8'h00));
			end else begin
				if (acc_digits != 0)
					res.push_back(close_run());
				res.push_back(plain_result(KIND_END_OK, 8'h00));
			end
			// every end starts a fresh stream
			acc_bits     = '0;
			acc_digits   = '0;
			esc_seen     = 1'b0;
			acc_overflow = 1'b0;
		end else if (esc_seen) begin
			esc_seen = 1'b0;
			res.push_back(plain_result(KIND_LITERAL,
				(b.in_byte != 8'h00) ? BYTE_ESC : BYTE_ESC_ZERO));
		end else if (b.in_byte <= 8'd1) begin
			// run digit, LSB first; beyond the digit limit only flag it
			if (acc_digits >= DIGIT_LIMIT) begin
				acc_overflow = 1'b1;
			end else begin
				if (b.in_byte[0] && acc_digits < BITS_LIMIT)
					acc_bits[acc_digits] = 1'b1;
				acc_digits = acc_digits + 1'b1;
			end
		end else begin
			if (acc_digits != 0)
				res.push_back(close_run());
			if (b.in_byte == BYTE_ESC)
				esc_seen = 1'b1;
			else
				res.push_back(plain_result(KIND_LITERAL, b.in_byte - 8'd1));
		end
		if (res.size() != 0)
			res[res.size()-1].last = 1'b1;
		foreach (res[i])
			pending_results.push_back(res[i]);
	endtask

	// Offer one beat: random idle gap first, then hold it until accepted.
	task automatic send_beat(input action_t a, input logic [7:0] d);
		in_beat_t b;
		b.action  = a;
		b.in_byte = d;
		while ($urandom_range(99) < src_idle_pct) begin
			@(negedge clk);
			byte_valid <= 1'b0;
			byte_beat  <= $bits(in_beat_t)'($urandom);
		end
		@(negedge clk);
		byte_valid <= 1'b1;
		byte_beat  <= b;
		do @(posedge clk); while (byte_stall);
		decode_beat(b);
		beats_sent++;
	endtask

	task automatic send_data(input logic [7:0] d);
		send_beat(ACT_DATA, d);
	endtask

	task automatic send_end();
		send_beat(ACT_END, 8'($urandom));
	endtask

	task automatic send_digits(input int n);
		repeat (n) send_data(8'($urandom_range(1)));
	endtask

	// Drop valid, then wait for the block to deliver everything owed.
	task automatic drain();
		@(negedge clk);
		byte_valid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
	endtask

	// Receiver: random stall, forced high while a hold-off runs.
	always @(negedge clk)
		result_stall <= hold_active || ($urandom_range(99) < sink_stall_pct);

	// Hold-off window, counted on rising edges so the receiver reads it cleanly.
	always begin
		@(hold_go);
		hold_active = 1'b1;
		repeat (HOLD_CYCLES) @(posedge clk);
		hold_active = 1'b0;
	end

	// Result checker: each accepted result against the oldest prediction.
	always @(posedge clk) begin
		out_beat_t exp_r;
		if (arst_n && result_valid && !result_stall) begin
			if (pending_results.size() == 0) begin
				if (err_cnt < MAX_REPORTS)
					$display("result %0d: unexpected beat kind=%0d value=%02h",
						result_idx, result_beat.kind, result_beat.value,
						" len=%08h sat=%b last=%b",
						result_beat.run_length, result_beat.run_saturated,
						result_beat.last);
				err_cnt++;
			end else begin
				exp_r = pending_results.pop_front();
				if (result_beat.kind !== exp_r.kind
						|| result_beat.value !== exp_r.value
						|| result_beat.run_length !== exp_r.run_length
						|| result_beat.run_saturated !== exp_r.run_saturated
						|| result_beat.last !== exp_r.last) begin
					if (err_cnt < MAX_REPORTS)
						$display("result %0d: exp kind=%0d value=%02h len=%08h sat=%b last=%b,",
							result_idx, exp_r.kind, exp_r.value, exp_r.run_length,
							exp_r.run_saturated, exp_r.last,
							" got kind=%0d value=%02h len=%08h sat=%b last=%b",
							result_beat.kind, result_beat.value,
							result_beat.run_length, result_beat.run_saturated,
							result_beat.last);
					err_cnt++;
				end
			end
			result_idx++;
		end
	end

	// Short directed stream: literal extremes, runs closed every way, escapes, ends.
	task automatic test_directed();
		src_idle_pct   = 0;
		sink_stall_pct = 0;
		send_data(8'h02);           // smallest literal
		send_data(8'hfe);           // largest plain literal
		send_data(8'h00);           // one digit, run of 1 ...
		send_data(8'h05);           // ... closed by a literal: two results
		send_data(8'h01);
		send_data(8'h01);
		send_data(BYTE_ESC);        // closes run of 6, escape: one result
		send_data(8'h00);           // escaped zero
		send_data(BYTE_ESC);
		send_data(8'h01);           // escaped digit is a byte, not a digit
		send_data(BYTE_ESC);
		send_data(8'h80);
		send_data(BYTE_ESC);
		send_data(BYTE_ESC);        // escaped escape
		send_data(8'h01);
		send_end();                 // run then end ok
		send_data(BYTE_ESC);
		send_end();                 // end right after escape
		send_end();                 // bare end
		drain();
	endtask

	// Runs at and past the digit limit.
	task automatic test_long_runs();
		src_idle_pct   = 10;
		sink_stall_pct = 10;
		repeat (RUN_DIGITS) send_data(8'h01);   // longest exact run
		send_end();
		send_digits(RUN_DIGITS + 1);            // one digit dropped
		send_data(8'h02);
		repeat (RUN_DIGITS + 9) send_data(8'h00);
		send_data(BYTE_ESC);
		send_data(8'h00);
		send_digits(RUN_DIGITS);
		send_data(8'($urandom_range(2, 255)));
		send_end();
		drain();
	endtask

	// One random token of a mostly well-formed stream.
	task automatic send_token();
		int sel;
		int pick;
		sel = $urandom_range(99);
		if (sel < 30) begin
			pick = $urandom_range(99);
			if (pick < 70)
				send_digits($urandom_range(1, 6));
			else if (pick < 95)
				send_digits($urandom_range(7, RUN_DIGITS - 1));
			else
				send_digits($urandom_range(RUN_DIGITS, RUN_DIGITS + 9));
		end else if (sel < 55) begin
			send_data(8'($urandom_range(2, 254)));
		end else if (sel < 70) begin
			send_data(BYTE_ESC);
			pick = $urandom_range(2);
			send_data(pick == 0 ? 8'h00 : pick == 1 ? 8'h01 : 8'($urandom));
		end else if (sel < 80) begin
			send_end();
		end else if (sel < 85) begin
			send_data(BYTE_ESC);
			send_end();
		end else begin
			// noise: any byte, now and then an end
			send_beat(($urandom_range(9) == 0) ? ACT_END : ACT_DATA, 8'($urandom));
		end
	endtask

	task automatic run_random(input int n_beats, input int idle_pct, input int stall_pct);
		int target;
		src_idle_pct   = idle_pct;
		sink_stall_pct = stall_pct;
		target = beats_sent + n_beats;
		while (beats_sent < target)
			send_token();
		drain();
	endtask

	task automatic test_random_no_idle();
		run_random(450, 0, 0);
	endtask

	task automatic test_random_sender_idle();
		run_random(450, 46, 0);
	endtask

	task automatic test_random_receiver_stall();
		run_random(450, 0, 46);
	endtask

	task automatic test_random_both_idle();
		run_random(400, 24, 24);
	endtask

	// Receiver holds off while the sender keeps offering: queue fills, input stalls.
	task automatic test_backpressure();
		int target;
		src_idle_pct   = 0;
		sink_stall_pct = 0;
		-> hold_go;
		target = beats_sent + 40;
		while (beats_sent < target)
			send_token();
		drain();
	endtask

	initial begin
		repeat (RESET_CYCLES) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		test_directed();
		test_long_runs();
		test_random_no_idle();
		test_random_sender_idle();
		test_random_receiver_stall();
		test_random_both_idle();
		test_backpressure();

		// all owed results are in; watch for strays a while longer
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (pending_results.size() != 0)
			err_cnt++;

		if (err_cnt == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

	// Watchdog against a hung handshake.
	initial begin
		#TIMEOUT_NS;
		$display("CHECKS FAILED");
		$finish;
	end

endmodule

`default_nettype wire
